// File: design/ptf_pkg.sv
// Shared constants, types and register codes for the pattern trim filter.
package ptf_pkg;

  localparam int BYTE_W          = 8;
  localparam int PATTERN_MAX_DEF = 16;
  localparam int LEN_REG_W       = 5;
  localparam int MODE_W          = 2;
  localparam int WORD_W          = 64;
  localparam int REG_IDX_W       = 2;
  localparam int CMD_QUEUE_DEPTH = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_COLLAPSE = 2'd0,
    MODE_DELETE   = 2'd1,
    MODE_PREFIX   = 2'd2,
    MODE_SUFFIX   = 2'd3
  } trim_mode_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TRIM_MODE      = 2'd0,
    REG_PATTERN_LENGTH = 2'd1,
    REG_WORD_LOW       = 2'd2,
    REG_WORD_HIGH      = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic              en;
    reg_index_t        index;
    logic [WORD_W-1:0] data;
  } cfg_write_t;

endpackage

// File: design/ptf_front.sv
// Front end: config registers, holdback window, pattern compare and command issue.
module ptf_front import ptf_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int LEN_W       = $clog2(PATTERN_MAX + 1),
  parameter int CMD_W       = PATTERN_MAX * BYTE_W + LEN_W + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_write_t        cfg,
  input  logic [BYTE_W-1:0] text_byte,
  input  logic              text_last,
  input  logic              in_push,
  input  logic              q_full,
  output logic              q_push,
  output logic [CMD_W-1:0]  q_data
);

  typedef enum logic [1:0] {WIN_KEEP, WIN_SHIFT, WIN_CLEAR} win_op_t;

  // config
  trim_mode_t            trim_mode;
  logic [LEN_REG_W-1:0]  pattern_length;
  logic [WORD_W-1:0]     word_low;
  logic [WORD_W-1:0]     word_high;

  // string state
  logic [PATTERN_MAX-1:0][BYTE_W-1:0] window;
  logic [LEN_W-1:0]                   fill;
  logic                               after_run;
  logic                               prefix_decided;

  logic [2*WORD_W-1:0]                pat_all;
  logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat;
  logic [PATTERN_MAX-1:0][BYTE_W-1:0] w_ins;
  logic [PATTERN_MAX-1:0][BYTE_W-1:0] w_shift;
  logic [LEN_W-1:0]                   eff_len;
  logic [LEN_W-1:0]                   fill_n;
  logic [LEN_W-1:0]                   fill_next;
  logic [LEN_W-1:0]                   keep_cnt;
  logic                               win_full;
  logic                               match;
  logic                               drop;
  logic                               after_next;
  logic                               decided_next;
  logic                               accept;
  win_op_t                            win_op;

  assign pat_all = {word_high, word_low};
  assign accept  = in_push && !q_full;
  assign fill_n  = fill + LEN_W'(1);

  always_comb begin
    if (pattern_length > LEN_REG_W'(PATTERN_MAX)) begin
      eff_len = LEN_W'(PATTERN_MAX);
    end else begin
      eff_len = LEN_W'(pattern_length);
    end
  end

  // new byte goes in at the fill position; shifted copy drops the oldest
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      pat[i]   = pat_all[i*BYTE_W +: BYTE_W];
      w_ins[i] = (LEN_W'(i) == fill) ? text_byte : window[i];
    end
    for (int i = 0; i < PATTERN_MAX - 1; i++) begin
      w_shift[i] = w_ins[i+1];
    end
    w_shift[PATTERN_MAX-1] = w_ins[PATTERN_MAX-1];
  end

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (LEN_W'(i) < eff_len && w_ins[i] != pat[i]) begin
        match = 1'b0;
      end
    end
  end

  assign win_full = (fill_n >= eff_len);

  // keep_cnt: how many leading bytes of w_ins this byte releases
  always_comb begin
    keep_cnt     = '0;
    win_op       = WIN_KEEP;
    after_next   = after_run;
    decided_next = prefix_decided;
    drop         = 1'b0;
    if (eff_len == '0) begin
      keep_cnt = LEN_W'(1);
      win_op   = WIN_CLEAR;
    end else begin
      unique case (trim_mode)
        MODE_COLLAPSE, MODE_DELETE: begin
          drop = win_full && match && (trim_mode == MODE_DELETE || after_run);
          if (win_full) begin
            if (match) begin
              win_op = WIN_CLEAR;
              if (!drop) begin
                keep_cnt   = eff_len;
                after_next = 1'b1;
              end
            end else begin
              keep_cnt   = LEN_W'(1);
              win_op     = WIN_SHIFT;
              after_next = 1'b0;
            end
          end
          if (text_last) begin
            keep_cnt = drop ? '0 : fill_n;
          end
        end
        MODE_PREFIX: begin
          // once decided the window is empty, so w_ins[0] is the new byte
          if (prefix_decided) begin
            keep_cnt = LEN_W'(1);
            win_op   = WIN_CLEAR;
          end else if (win_full) begin
            decided_next = 1'b1;
            win_op       = WIN_CLEAR;
            keep_cnt     = match ? '0 : eff_len;
          end else begin
            keep_cnt = text_last ? fill_n : '0;
          end
        end
        MODE_SUFFIX: begin
          // hold len-1 bytes; the final byte decides
          if (text_last) begin
            keep_cnt = (win_full && match) ? '0 : fill_n;
          end else if (win_full) begin
            keep_cnt = LEN_W'(1);
            win_op   = WIN_SHIFT;
          end
        end
        default: begin
          keep_cnt = '0;
        end
      endcase
    end
    if (text_last) begin
      win_op       = WIN_CLEAR;
      after_next   = 1'b0;
      decided_next = 1'b0;
    end
  end

  always_comb begin
    unique case (win_op)
      WIN_KEEP:  fill_next = fill_n;
      WIN_SHIFT: fill_next = fill;
      WIN_CLEAR: fill_next = '0;
      default:   fill_next = '0;
    endcase
  end

  assign q_push = accept && (keep_cnt != '0 || text_last);
  assign q_data = {w_ins, keep_cnt, text_last};

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_mode      <= MODE_COLLAPSE;
      pattern_length <= '0;
      word_low       <= '0;
      word_high      <= '0;
      fill           <= '0;
      after_run      <= 1'b0;
      prefix_decided <= 1'b0;
    end else if (cfg.en) begin
      unique case (cfg.index)
        REG_TRIM_MODE:      trim_mode      <= trim_mode_t'(cfg.data[MODE_W-1:0]);
        REG_PATTERN_LENGTH: pattern_length <= cfg.data[LEN_REG_W-1:0];
        REG_WORD_LOW:       word_low       <= cfg.data;
        REG_WORD_HIGH:      word_high      <= cfg.data;
        default:            trim_mode      <= trim_mode;
      endcase
      fill           <= '0;
      after_run      <= 1'b0;
      prefix_decided <= 1'b0;
    end else if (accept) begin
      fill           <= fill_next;
      after_run      <= after_next;
      prefix_decided <= decided_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window <= (win_op == WIN_SHIFT) ? w_shift : w_ins;
    end
  end

endmodule

// File: design/ptf_queue.sv
// Small command queue between the front end and the output sequencer.
module ptf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             has_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full     = (count == CNT_W'(DEPTH));
  assign has_data = (count != '0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && has_data;
  assign rd_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

// File: design/ptf_back.sv
// Back end: expands queued commands into result words, one word per cycle while the result side is popped.
module ptf_back import ptf_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int LEN_W       = $clog2(PATTERN_MAX + 1),
  parameter int CMD_W       = PATTERN_MAX * BYTE_W + LEN_W + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  logic [CMD_W-1:0]  q_data,
  output logic              q_pop,
  output logic [BYTE_W-1:0] kept_byte,
  output logic              byte_present,
  output logic              result_last,
  output logic              empty,
  input  logic              pop
);

  logic [PATTERN_MAX-1:0][BYTE_W-1:0] q_bytes;
  logic [LEN_W-1:0]                   q_cnt;
  logic                               q_last;

  logic [PATTERN_MAX-1:0][BYTE_W-1:0] cur_bytes;
  logic [LEN_W-1:0]                   cur_cnt;
  logic                               cur_last;
  logic                               cur_valid;

  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_present;
  logic              out_last;

  logic out_free;
  logic emit;
  logic finishing;
  logic load;

  assign q_bytes = q_data[CMD_W-1 -: PATTERN_MAX*BYTE_W];
  assign q_cnt   = q_data[LEN_W:1];
  assign q_last  = q_data[0];

  assign out_free  = !out_valid || pop;
  assign emit      = cur_valid && out_free;
  // a zero count is a bare end marker and also ends the command
  assign finishing = emit && (cur_cnt <= LEN_W'(1));
  assign load      = q_valid && (!cur_valid || finishing);
  assign q_pop     = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        cur_valid <= 1'b1;
      end else if (finishing) begin
        cur_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_bytes <= q_bytes;
      cur_cnt   <= q_cnt;
      cur_last  <= q_last;
    end else if (emit) begin
      cur_bytes <= cur_bytes >> BYTE_W;
      cur_cnt   <= cur_cnt - LEN_W'(1);
    end
    if (emit) begin
      out_byte    <= (cur_cnt == '0) ? '0 : cur_bytes[0];
      out_present <= (cur_cnt != '0);
      out_last    <= cur_last && (cur_cnt <= LEN_W'(1));
    end
  end

  assign kept_byte    = out_byte;
  assign byte_present = out_present;
  assign result_last  = out_last;
  assign empty        = !out_valid;

endmodule

// File: design/pattern_trim_filter.sv
// Top level of the pattern trim filter.
//
// Streams string bytes (text_byte, text_last on the final byte) and removes a
// configured pattern of up to PATTERN_MAX bytes: collapse repeats, delete all,
// strip one leading copy, or strip one trailing copy (trim_mode 0..3). A
// pattern_length of zero passes bytes straight through; a length above
// PATTERN_MAX acts as PATTERN_MAX, and a string shorter than the pattern is
// kept whole. Input takes one byte per cycle while full is low, and the result side
// delivers one word per cycle while it is popped. The front end compares the whole
// holdback window against the pattern combinationally and issues a command for each
// byte that releases bytes or ends a string; a two-entry command queue feeds the
// output sequencer, which shifts the released bytes out one per cycle unless the
// result side stalls. A single byte can release up to pattern_length words (a
// kept match in collapse mode, a failed leading compare in prefix mode, or a
// string end), so after such a burst the input can show full while the sequencer
// drains. A string end that releases nothing yields one bare end word
// (byte_present low, kept_byte zero, result_last high). Config writes take
// effect at once and discard any string in progress; write only when idle.
// No clearing pass is needed after reset.
module pattern_trim_filter import ptf_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // byte input, queue style
  input  logic [BYTE_W-1:0]    text_byte,
  input  logic                 text_last,
  input  logic                 push,
  output logic                 full,
  // result output, queue style
  output logic [BYTE_W-1:0]    kept_byte,
  output logic                 byte_present,
  output logic                 result_last,
  output logic                 empty,
  input  logic                 pop,
  // register writes
  input  logic                 write_en,
  input  logic [REG_IDX_W-1:0] write_index,
  input  logic [WORD_W-1:0]    write_data
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  // command word: released window bytes, release count, end-of-string flag
  localparam int CMD_W = PATTERN_MAX * BYTE_W + LEN_W + 1;

  cfg_write_t       cfg;
  logic             q_push;
  logic             q_full;
  logic [CMD_W-1:0] q_wr_data;
  logic             q_pop;
  logic [CMD_W-1:0] q_rd_data;
  logic             q_has_data;

  assign cfg.en    = write_en;
  assign cfg.index = reg_index_t'(write_index);
  assign cfg.data  = write_data;

  // full comes straight from the queue count
  assign full = q_full;

  ptf_front #(
    .PATTERN_MAX (PATTERN_MAX),
    .LEN_W       (LEN_W),
    .CMD_W       (CMD_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .text_byte (text_byte),
    .text_last (text_last),
    .in_push   (push),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wr_data)
  );

  ptf_queue #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_data  (q_wr_data),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_data  (q_rd_data),
    .has_data (q_has_data)
  );

  ptf_back #(
    .PATTERN_MAX (PATTERN_MAX),
    .LEN_W       (LEN_W),
    .CMD_W       (CMD_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_has_data),
    .q_data       (q_rd_data),
    .q_pop        (q_pop),
    .kept_byte    (kept_byte),
    .byte_present (byte_present),
    .result_last  (result_last),
    .empty        (empty),
    .pop          (pop)
  );

endmodule

// File: design/ptf_checker.sv
// Port-level checks for the pattern trim filter, bound to the top level.
module ptf_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic [7:0] kept_byte,
  input logic       byte_present,
  input logic       result_last,
  input logic       empty,
  input logic       pop
);

  // reset leaves nothing pending and room for input
  a_reset_idle: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("not idle after reset");

  // a waiting word holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(kept_byte) && $stable(byte_present)
                       && $stable(result_last))
    else $error("result word changed while stalled");

  // a word without a byte only ever closes a string
  a_bare_is_last: assert property (@(posedge clk) disable iff (rst)
    !empty && !byte_present |-> result_last)
    else $error("bare word without result_last");

  a_bare_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && !byte_present |-> kept_byte == 8'd0)
    else $error("bare word with nonzero byte");

endmodule

bind pattern_trim_filter ptf_checker u_ptf_checker (
  .clk          (clk),
  .rst          (rst),
  .full         (full),
  .kept_byte    (kept_byte),
  .byte_present (byte_present),
  .result_last  (result_last),
  .empty        (empty),
  .pop          (pop)
);

// File: verif/tb_top.sv
// Self-checking testbench for pattern_trim_filter: directed and random strings vs. a trim predictor.
`timescale 1ns / 100ps

module tb_top;
  import ptf_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 12;
  localparam int SETTLE       = 48;     // > longest release burst plus command queue
  localparam int RAND_TARGET  = 285;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int IDLE_PCT     = 16;
  localparam int PMAX         = PATTERN_MAX_DEF;

  // one input word and one result word
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              fin;
  } text_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              present;
    logic              fin;
  } trim_word_t;

  logic                 clk;
  logic                 rst         = 1'b1;
  logic [BYTE_W-1:0]    text_byte   = '0;
  logic                 text_last   = 1'b0;
  logic                 push        = 1'b0;
  logic                 full;
  logic [BYTE_W-1:0]    kept_byte;
  logic                 byte_present;
  logic                 result_last;
  logic                 empty;
  logic                 pop         = 1'b0;
  logic                 write_en    = 1'b0;
  logic [REG_IDX_W-1:0] write_index = '0;
  logic [WORD_W-1:0]    write_data  = '0;

  pattern_trim_filter u_dut (
    .clk          (clk),
    .rst          (rst),
    .text_byte    (text_byte),
    .text_last    (text_last),
    .push         (push),
    .full         (full),
    .kept_byte    (kept_byte),
    .byte_present (byte_present),
    .result_last  (result_last),
    .empty        (empty),
    .pop          (pop),
    .write_en     (write_en),
    .write_index  (write_index),
    .write_data   (write_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: register shadow plus the string-level holdback state.
  // ---------------------------------------------------------------------------
  trim_mode_t           cfg_mode = MODE_COLLAPSE;
  logic [LEN_REG_W-1:0] cfg_len  = '0;
  logic [WORD_W-1:0]    cfg_lo   = '0;
  logic [WORD_W-1:0]    cfg_hi   = '0;
  logic [BYTE_W-1:0]    hold_win [PMAX];
  int                   hold_cnt  = 0;
  bit                   run_flag  = 1'b0;   // collapse: just kept a match
  bit                   lead_done = 1'b0;   // prefix: string start settled

  trim_word_t           burst_q   [$];      // words released by one input word
  trim_word_t           trimmed_q [$];      // expected words, oldest first
  text_word_t           text_q    [$];      // words waiting for the driver
  logic [BYTE_W-1:0]    draft_q   [$];      // string under construction

  int queued_cnt = 0;
  int taken_cnt  = 0;
  int mismatches = 0;
  int cycle_cnt  = 0;
  int rand_items = 0;
  bit calm       = 1'b0;                    // no idling on either side

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic logic [BYTE_W-1:0] pat_at(int i);
    return (i < 8) ? cfg_lo[8*i +: 8] : cfg_hi[8*(i-8) +: 8];
  endfunction

  // lengths past the window size saturate
  function automatic int active_len();
    return (cfg_len > PMAX) ? PMAX : int'(cfg_len);
  endfunction

  function automatic bit window_is_pattern(int n);
    for (int i = 0; i < n; i++)
      if (hold_win[i] != pat_at(i)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void keep(logic [BYTE_W-1:0] b);
    burst_q.push_back('{data: b, present: 1'b1, fin: 1'b0});
  endfunction

  function automatic void release_window();
    for (int i = 0; i < hold_cnt; i++) keep(hold_win[i]);
    hold_cnt = 0;
  endfunction

  function automatic void retire_oldest();
    for (int i = 0; i < PMAX - 1; i++) hold_win[i] = hold_win[i+1];
    hold_cnt--;
  endfunction

  function automatic void clear_hold();
    foreach (hold_win[i]) hold_win[i] = '0;
    hold_cnt  = 0;
    run_flag  = 1'b0;
    lead_done = 1'b0;
  endfunction

  // Works out the words one accepted input word releases and queues them.
  function automatic void predict_trim(logic [BYTE_W-1:0] b, logic is_end);
    int         n;
    bit         hit;
    trim_word_t tail;
    n = active_len();
    burst_q.delete();
    if (n == 0) begin
      keep(b);
    end else if (cfg_mode == MODE_COLLAPSE || cfg_mode == MODE_DELETE) begin
      hold_win[hold_cnt % PMAX] = b;
      hold_cnt++;
      if (hold_cnt >= n) begin
        if (window_is_pattern(n)) begin
          if (cfg_mode == MODE_DELETE || run_flag) begin
            hold_cnt = 0;
          end else begin
            release_window();
            run_flag = 1'b1;
          end
        end else begin
          keep(hold_win[0]);
          retire_oldest();
          run_flag = 1'b0;
        end
      end
      if (is_end) release_window();
    end else if (cfg_mode == MODE_PREFIX) begin
      if (lead_done) begin
        keep(b);
      end else begin
        hold_win[hold_cnt % PMAX] = b;
        hold_cnt++;
        if (hold_cnt >= n) begin
          if (window_is_pattern(n)) hold_cnt = 0;
          else release_window();
          lead_done = 1'b1;
        end
        // string shorter than the pattern is kept whole
        if (is_end) release_window();
      end
    end else begin
      // suffix: hold n-1 words back, decide on the final word
      if (is_end) begin
        hit = (hold_cnt == n - 1) && (b == pat_at(n - 1)) && window_is_pattern(hold_cnt);
        if (hit) begin
          hold_cnt = 0;
        end else begin
          release_window();
          keep(b);
        end
      end else if (n == 1) begin
        keep(b);
      end else begin
        if (hold_cnt >= n - 1) begin
          keep(hold_win[0]);
          retire_oldest();
        end
        hold_win[hold_cnt % PMAX] = b;
        hold_cnt++;
      end
    end
    if (is_end) begin
      // tag the final word, or emit a bare end word when nothing survived
      if (burst_q.size() == 0) begin
        tail = '{data: '0, present: 1'b0, fin: 1'b1};
      end else begin
        tail     = burst_q.pop_back();
        tail.fin = 1'b1;
      end
      burst_q.push_back(tail);
      clear_hold();
    end
    foreach (burst_q[i]) trimmed_q.push_back(burst_q[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feeds text_q into the push side, holds a word while full is high.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : text_driver
    text_word_t nxt;
    if (rst) begin
      push <= 1'b0;
    end else if (!push || !full) begin
      if (text_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt = text_q.pop_front();
        push      <= 1'b1;
        text_byte <= nxt.data;
        text_last <= nxt.fin;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on input acceptance first, then checks the popped word,
  // so a same-edge result still finds its expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : trim_monitor
    trim_word_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      if (push && !full) begin
        predict_trim(text_byte, text_last);
        taken_cnt++;
      end
      if (pop && !empty) begin
        if (trimmed_q.size() == 0) begin
          $display("%0t: unexpected word: kept_byte %h byte_present %b result_last %b",
                   $time, kept_byte, byte_present, result_last);
          mismatches++;
        end else begin
          want = trimmed_q.pop_front();
          if (kept_byte !== want.data) begin
            $display("%0t: kept_byte expected %h actual %h", $time, want.data, kept_byte);
            mismatches++;
          end
          if (byte_present !== want.present) begin
            $display("%0t: byte_present expected %b actual %b",
                     $time, want.present, byte_present);
            mismatches++;
          end
          if (result_last !== want.fin) begin
            $display("%0t: result_last expected %b actual %b", $time, want.fin, result_last);
            mismatches++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_text(logic [BYTE_W-1:0] b, logic is_end);
    text_q.push_back('{data: b, fin: is_end});
    queued_cnt++;
  endfunction

  function automatic void queue_chars(string s);
    for (int i = 0; i < s.len(); i++) queue_text(s[i], i == s.len() - 1);
  endfunction

  // Everything sent has been taken and every expected word popped, then the
  // block gets time to finish any burst that produced no word.
  task automatic wait_drained();
    while (taken_cnt != queued_cnt || trimmed_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Shadow is updated first; the block is idle so timing does not matter.
  task automatic write_reg(reg_index_t idx, logic [WORD_W-1:0] val);
    case (idx)
      REG_TRIM_MODE:      cfg_mode = trim_mode_t'(val[MODE_W-1:0]);
      REG_PATTERN_LENGTH: cfg_len  = val[LEN_REG_W-1:0];
      REG_WORD_LOW:       cfg_lo   = val;
      REG_WORD_HIGH:      cfg_hi   = val;
    endcase
    clear_hold();
    @(posedge clk);
    write_en    <= 1'b1;
    write_index <= idx;
    write_data  <= val;
    @(posedge clk);
    write_en <= 1'b0;
  endtask

  task automatic set_config(trim_mode_t mode, int plen, logic [WORD_W-1:0] lo,
                            logic [WORD_W-1:0] hi);
    wait_drained();
    write_reg(REG_TRIM_MODE, WORD_W'(mode));
    write_reg(REG_PATTERN_LENGTH, WORD_W'(plen));
    write_reg(REG_WORD_LOW, lo);
    write_reg(REG_WORD_HIGH, hi);
  endtask

  // Two-letter patterns give self-overlapping matches; others are flat or random.
  function automatic void pick_pattern(output logic [WORD_W-1:0] lo,
                                       output logic [WORD_W-1:0] hi);
    int                k;
    logic [BYTE_W-1:0] a, c;
    logic [127:0]      all;
    k = $urandom_range(0, 9);
    if (k == 0) begin
      all = '0;
    end else if (k == 1) begin
      all = '1;
    end else if (k < 6) begin
      a = 8'($urandom);
      c = 8'($urandom);
      for (int i = 0; i < 16; i++) all[8*i +: 8] = $urandom_range(0, 1) ? a : c;
    end else begin
      all = {$urandom, $urandom, $urandom, $urandom};
    end
    lo = all[63:0];
    hi = all[127:64];
  endfunction

  // A string is a few segments: whole pattern copies, leading fragments,
  // bytes from the pattern's own alphabet, and plain noise.
  function automatic void build_string(int n);
    int segs, kind, part;
    draft_q.delete();
    segs = $urandom_range(1, 4);
    for (int s = 0; s < segs; s++) begin
      kind = $urandom_range(0, 99);
      if (n > 0 && kind < 40) begin
        for (int i = 0; i < n; i++) draft_q.push_back(pat_at(i));
      end else if (n > 1 && kind < 55) begin
        part = $urandom_range(1, n - 1);
        for (int i = 0; i < part; i++) draft_q.push_back(pat_at(i));
      end else if (n > 0 && kind < 80) begin
        repeat ($urandom_range(1, 3)) draft_q.push_back(pat_at($urandom_range(0, n - 1)));
      end else begin
        repeat ($urandom_range(1, 3)) draft_q.push_back(8'($urandom));
      end
    end
  endfunction

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [WORD_W-1:0] lo_w, hi_w;
    trim_mode_t        mode;
    int                plen, pick, goal, phase_items, phase;
    bit                cut;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset config is a zero-length pattern: straight pass-through
    queue_text(8'h00, 1'b0);
    queue_text(8'hFF, 1'b1);

    // collapse "ab": first copy kept, the run after it dropped
    set_config(MODE_COLLAPSE, 2, 64'h6261, '0);
    queue_chars("abababc");

    // delete "ab": every copy goes; a string of one copy leaves a bare end word
    set_config(MODE_DELETE, 2, 64'h6261, '0);
    queue_chars("aabab");
    queue_chars("ab");

    // prefix: one leading copy only; text shorter than the pattern is kept
    set_config(MODE_PREFIX, 2, 64'h6261, '0);
    queue_chars("abab");
    queue_chars("a");

    // suffix "abc"
    set_config(MODE_SUFFIX, 3, 64'h636261, '0);
    queue_chars("xabc");

    // random phases; the first few pin the register extremes
    phase = 0;
    while (rand_items < RAND_TARGET) begin
      pick_pattern(lo_w, hi_w);
      case (phase)
        0: begin
          plen = PMAX;
          lo_w = '1;
          hi_w = '1;
        end
        1: begin
          plen = 0;
          lo_w = '0;
          hi_w = '0;
        end
        2: plen = 31;                 // saturates to the window size
        default: begin
          pick = $urandom_range(0, 9);
          if (pick == 0) plen = 0;
          else if (pick == 1) plen = $urandom_range(7, PMAX);
          else if (pick == 2) plen = $urandom_range(PMAX + 1, 31);
          else plen = $urandom_range(1, 6);
        end
      endcase
      mode = (phase < 4) ? trim_mode_t'(2'(3 - phase)) : trim_mode_t'($urandom_range(0, 3));
      set_config(mode, plen, lo_w, hi_w);
      calm = (phase == 3 || phase == 4);   // long stretch with no idling

      goal        = $urandom_range(8, 24);
      phase_items = 0;
      while (phase_items < goal) begin
        build_string(active_len());
        // now and then leave the string open; the next write drops it
        cut = ($urandom_range(0, 99) < 10);
        foreach (draft_q[i]) queue_text(draft_q[i], !cut && i == draft_q.size() - 1);
        phase_items += draft_q.size();
        rand_items  += draft_q.size();
        if (cut) phase_items = goal;
        else if ($urandom_range(0, 99) < 8) wait_drained();   // sender holds off
      end
      phase++;
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
